@@ rtl/srt_pkg.sv @@
// Shared types, codes and constants of the sorted record table.
`default_nettype none

package srt_pkg;

    localparam int SRT_CAPACITY = 16;

    localparam int KIND_W   = 2;
    localparam int KEY_W    = 32;
    localparam int TAG_W    = 32;
    localparam int GENDER_W = 2;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 3;
    localparam int WHERE_W  = 4;
    localparam int HELD_W   = 5;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_RANGE     = 3'd4;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
        logic [GENDER_W-1:0]     gender;
    } rec_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_FETCH,
        S_INS_SHIFT,
        S_LK_FETCH,
        S_LK_SCAN,
        S_RD_FETCH,
        S_RD_TAKE,
        S_EMIT
    } state_t;

    // Read address relative to the walking index
    typedef enum logic [1:0] {
        RA_CUR,
        RA_NEXT,
        RA_PREV,
        RA_PREV2
    } rd_sel_t;

    // What the staging register takes
    typedef enum logic [2:0] {
        RES_INSERTED,
        RES_FULL,
        RES_FOUND,
        RES_NOT_FOUND,
        RES_RANGE,
        RES_NOOP
    } res_sel_t;

    typedef struct packed {
        logic     take;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     shift;
        logic     place;
        logic     advance;
        logic     stage_en;
        res_sel_t stage_sel;
        logic     emit;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic cnt_zero;
        logic idx_zero;
        logic idx_one;
        logic key_gt;
        logic key_eq;
        logic last;
        logic in_range;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/srt_ctrl.sv @@
// Sequencer of the sorted record table: one item at a time.
`default_nettype none

module srt_ctrl (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    input  wire logic [srt_pkg::KIND_W-1:0] s_kind,
    output logic                          s_ready,
    input  wire srt_pkg::dp_stat_t        stat,
    output srt_pkg::dp_cmd_t              cmd
);
    import srt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (s_kind)
                        KIND_INSERT: state_next = stat.full ? S_EMIT : S_INS_FETCH;
                        KIND_LOOKUP: state_next = S_LK_FETCH;
                        KIND_READ:   state_next = S_RD_FETCH;
                        default:     state_next = S_EMIT;
                    endcase
                end
            end
            S_INS_FETCH: state_next = stat.idx_zero ? S_EMIT : S_INS_SHIFT;
            S_INS_SHIFT: begin
                if (stat.key_gt) begin
                    state_next = stat.idx_one ? S_INS_FETCH : S_INS_SHIFT;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_LK_FETCH: state_next = stat.cnt_zero ? S_EMIT : S_LK_SCAN;
            S_LK_SCAN: begin
                if (stat.key_eq || stat.last) begin
                    state_next = S_EMIT;
                end
            end
            S_RD_FETCH: state_next = stat.in_range ? S_RD_TAKE : S_EMIT;
            S_RD_TAKE:  state_next = S_EMIT;
            S_EMIT: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        cmd       = '0;
        cmd.rd_sel    = RA_CUR;
        cmd.stage_sel = RES_NOOP;
        s_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take = 1'b1;
                    unique case (s_kind)
                        KIND_INSERT: begin
                            if (stat.full) begin
                                cmd.stage_en  = 1'b1;
                                cmd.stage_sel = RES_FULL;
                            end
                        end
                        KIND_LOOKUP, KIND_READ: ;
                        default: begin
                            cmd.stage_en  = 1'b1;
                            cmd.stage_sel = RES_NOOP;
                        end
                    endcase
                end
            end
            S_INS_FETCH: begin
                if (stat.idx_zero) begin
                    cmd.place     = 1'b1;
                    cmd.stage_en  = 1'b1;
                    cmd.stage_sel = RES_INSERTED;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_PREV;
                end
            end
            S_INS_SHIFT: begin
                if (stat.key_gt) begin
                    cmd.shift  = 1'b1;
                    cmd.rd_en  = !stat.idx_one;
                    cmd.rd_sel = RA_PREV2;
                end else begin
                    cmd.place     = 1'b1;
                    cmd.stage_en  = 1'b1;
                    cmd.stage_sel = RES_INSERTED;
                end
            end
            S_LK_FETCH: begin
                if (stat.cnt_zero) begin
                    cmd.stage_en  = 1'b1;
                    cmd.stage_sel = RES_NOT_FOUND;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_CUR;
                end
            end
            S_LK_SCAN: begin
                if (stat.key_eq) begin
                    cmd.stage_en  = 1'b1;
                    cmd.stage_sel = RES_FOUND;
                end else if (stat.last) begin
                    cmd.stage_en  = 1'b1;
                    cmd.stage_sel = RES_NOT_FOUND;
                end else begin
                    cmd.advance = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = RA_NEXT;
                end
            end
            S_RD_FETCH: begin
                if (stat.in_range) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_CUR;
                end else begin
                    cmd.stage_en  = 1'b1;
                    cmd.stage_sel = RES_RANGE;
                end
            end
            S_RD_TAKE: begin
                cmd.stage_en  = 1'b1;
                cmd.stage_sel = RES_FOUND;
            end
            S_EMIT: begin
                cmd.emit = stat.out_free;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/srt_datapath.sv @@
// Record memory, walking index, count, staging and output registers.
`default_nettype none

module srt_datapath #(
    parameter int CAPACITY = srt_pkg::SRT_CAPACITY
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire srt_pkg::dp_cmd_t               cmd,
    output srt_pkg::dp_stat_t                   stat,
    input  wire logic [srt_pkg::KIND_W-1:0]     s_kind,
    input  wire logic signed [srt_pkg::KEY_W-1:0] s_key,
    input  wire logic [srt_pkg::TAG_W-1:0]      s_record_tag,
    input  wire logic [srt_pkg::GENDER_W-1:0]   s_gender_code,
    input  wire logic [srt_pkg::POS_W-1:0]      s_position,
    input  wire logic                           m_ready,
    output logic                                m_valid,
    output logic [srt_pkg::STATUS_W-1:0]        m_status,
    output logic [srt_pkg::WHERE_W-1:0]         m_where,
    output logic signed [srt_pkg::KEY_W-1:0]    m_found_key,
    output logic [srt_pkg::TAG_W-1:0]           m_found_tag,
    output logic [srt_pkg::GENDER_W-1:0]        m_found_gender,
    output logic [srt_pkg::HELD_W-1:0]          m_entries_held
);
    import srt_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    rec_t mem [CAPACITY];

    rec_t                    rdata_reg;
    logic signed [KEY_W-1:0] req_key_reg;
    logic [TAG_W-1:0]        req_tag_reg;
    logic [GENDER_W-1:0]     req_gender_reg;
    logic [POS_W-1:0]        req_pos_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [CNT_W-1:0]        count_reg;

    logic [STATUS_W-1:0]     stage_status_reg;
    logic [WHERE_W-1:0]      stage_where_reg;
    rec_t                    stage_rec_reg;

    logic                    m_valid_reg;
    logic [STATUS_W-1:0]     out_status_reg;
    logic [WHERE_W-1:0]      out_where_reg;
    rec_t                    out_rec_reg;
    logic [HELD_W-1:0]       out_held_reg;

    logic [IDX_W-1:0]         rd_addr;
    logic [IDX_W+WHERE_W-1:0] idx_ext;
    logic [WHERE_W-1:0]       idx_where;
    logic [CNT_W+HELD_W-1:0]  count_ext;
    logic [POS_W+IDX_W-1:0]   pos_ext;
    logic [IDX_W-1:0]         pos_idx;
    rec_t                     new_rec;

    // Width adaptation between index, count and the fixed port fields
    assign idx_ext   = {{WHERE_W{1'b0}}, idx_reg};
    assign idx_where = idx_ext[WHERE_W-1:0];
    assign count_ext = {{HELD_W{1'b0}}, count_reg};
    assign pos_ext   = {{IDX_W{1'b0}}, s_position};
    assign pos_idx   = pos_ext[IDX_W-1:0];

    assign new_rec.key    = req_key_reg;
    assign new_rec.tag    = req_tag_reg;
    assign new_rec.gender = req_gender_reg;

    always_comb begin
        unique case (cmd.rd_sel)
            RA_CUR:   rd_addr = idx_reg;
            RA_NEXT:  rd_addr = idx_reg + IDX_W'(1);
            RA_PREV:  rd_addr = idx_reg - IDX_W'(1);
            RA_PREV2: rd_addr = idx_reg - IDX_W'(2);
            default:  rd_addr = idx_reg;
        endcase
    end

    // Record memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.shift) begin
            mem[idx_reg] <= rdata_reg;
        end else if (cmd.place) begin
            mem[idx_reg] <= new_rec;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            req_key_reg    <= s_key;
            req_tag_reg    <= s_record_tag;
            req_gender_reg <= s_gender_code;
            req_pos_reg    <= s_position;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            unique case (s_kind)
                KIND_INSERT: idx_reg <= count_reg[IDX_W-1:0];
                KIND_READ:   idx_reg <= pos_idx;
                default:     idx_reg <= '0;
            endcase
        end else if (cmd.shift) begin
            idx_reg <= idx_reg - IDX_W'(1);
        end else if (cmd.advance) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.place) begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.stage_en) begin
            unique case (cmd.stage_sel)
                RES_INSERTED: begin
                    stage_status_reg <= STAT_INSERTED;
                    stage_where_reg  <= idx_where;
                    stage_rec_reg    <= new_rec;
                end
                RES_FULL: begin
                    stage_status_reg <= STAT_FULL;
                    stage_where_reg  <= '0;
                    stage_rec_reg    <= '0;
                end
                RES_FOUND: begin
                    stage_status_reg <= STAT_FOUND;
                    stage_where_reg  <= idx_where;
                    stage_rec_reg    <= rdata_reg;
                end
                RES_NOT_FOUND: begin
                    stage_status_reg <= STAT_NOT_FOUND;
                    stage_where_reg  <= '0;
                    stage_rec_reg    <= '0;
                end
                RES_RANGE: begin
                    stage_status_reg <= STAT_RANGE;
                    stage_where_reg  <= req_pos_reg;
                    stage_rec_reg    <= '0;
                end
                default: begin
                    stage_status_reg <= STAT_RANGE;
                    stage_where_reg  <= '0;
                    stage_rec_reg    <= '0;
                end
            endcase
        end
    end

    // Output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_status_reg <= stage_status_reg;
            out_where_reg  <= stage_where_reg;
            out_rec_reg    <= stage_rec_reg;
            out_held_reg   <= count_ext[HELD_W-1:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = out_status_reg;
    assign m_where        = out_where_reg;
    assign m_found_key    = out_rec_reg.key;
    assign m_found_tag    = out_rec_reg.tag;
    assign m_found_gender = out_rec_reg.gender;
    assign m_entries_held = out_held_reg;

    assign stat.full     = (count_reg == CNT_W'(CAPACITY));
    assign stat.cnt_zero = (count_reg == '0);
    assign stat.idx_zero = (idx_reg == '0);
    assign stat.idx_one  = (idx_reg == IDX_W'(1));
    assign stat.key_gt   = ($signed(rdata_reg.key) > $signed(req_key_reg));
    assign stat.key_eq   = (rdata_reg.key == req_key_reg);
    assign stat.last     = ((CNT_W'(idx_reg) + CNT_W'(1)) >= count_reg);
    assign stat.in_range = ({{CNT_W{1'b0}}, req_pos_reg} < {{POS_W{1'b0}}, count_reg});
    assign stat.out_free = !m_valid_reg || m_ready;

endmodule

`default_nettype wire

@@ rtl/sorted_record_table.sv @@
// Top level of the sorted record table.
`default_nettype none

// A table of up to CAPACITY records {key, tag, gender} kept in ascending
// signed key order in a single-port-write, single-port-read memory. Each input
// beat is one operation and gives exactly one result beat. Insert walks down
// from the top entry, moving each entry with a greater key up one place, one
// entry per cycle, and writes the record into the gap, so equal keys keep
// arrival order; a full table is reported without change. Lookup walks up from
// position 0, one entry per cycle, and reports the first equal key. Read
// returns the entry at a position, or out of range at or beyond the count.
// Kind 3 does nothing and reports out of range at position 0. One item is
// worked on at a time: an insert walks the entries with a greater key, a
// lookup walks up to the first equal key or through the whole count, a read
// takes its entry directly, and a full-table insert or kind 3 goes straight
// to the result step, so the longest item is a walk over the whole table.
// A result beat waiting at the output does not hold off the next input beat;
// the block only stalls in its last step until the output register is free.
// Memory contents come out of reset undefined; only entries below the count
// are ever read, so no clearing pass is needed.

module sorted_record_table #(
    parameter int CAPACITY = srt_pkg::SRT_CAPACITY
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [srt_pkg::KIND_W-1:0]       s_kind,
    input  wire logic signed [srt_pkg::KEY_W-1:0] s_key,
    input  wire logic [srt_pkg::TAG_W-1:0]        s_record_tag,
    input  wire logic [srt_pkg::GENDER_W-1:0]     s_gender_code,
    input  wire logic [srt_pkg::POS_W-1:0]        s_position,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [srt_pkg::STATUS_W-1:0]          m_status,
    output logic [srt_pkg::WHERE_W-1:0]           m_where,
    output logic signed [srt_pkg::KEY_W-1:0]      m_found_key,
    output logic [srt_pkg::TAG_W-1:0]             m_found_tag,
    output logic [srt_pkg::GENDER_W-1:0]          m_found_gender,
    output logic [srt_pkg::HELD_W-1:0]            m_entries_held
);
    import srt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer: decodes the beat kind and steps the memory walk
    srt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath: record memory, index, count, staging and output beat
    srt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_kind         (s_kind),
        .s_key          (s_key),
        .s_record_tag   (s_record_tag),
        .s_gender_code  (s_gender_code),
        .s_position     (s_position),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_status       (m_status),
        .m_where        (m_where),
        .m_found_key    (m_found_key),
        .m_found_tag    (m_found_tag),
        .m_found_gender (m_found_gender),
        .m_entries_held (m_entries_held)
    );

    // Never write a record into a full table
    a_place_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.place |-> !stat.full)
        else $error("record placed into a full table");

    // Never overwrite a result beat that has not been taken
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> stat.out_free)
        else $error("result beat overwritten");

    // A shift never moves below position zero
    a_shift_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.shift |-> !stat.idx_zero)
        else $error("shift below position zero");

    // One item at a time: no input beat right after an accepted one
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item is in progress");

endmodule

`default_nettype wire
